>>> rtl/htw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer wheel package
// Command codes, the controller state type and the cell control struct shared
// by the timer cells and the controller.
// ----------------------------------------------------------------------------
package htw_pkg;

    typedef enum logic [1:0] {
        CMD_ADD     = 2'd0,
        CMD_DELETE  = 2'd1,
        CMD_ADVANCE = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_EMIT   = 2'd2
    } t_state;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic        add;
        logic        del;
        logic        scan;
        logic        fire;
        logic        clear;
        logic [31:0] expiry;
        logic [31:0] cur_time;
        logic [31:0] span;
        logic [5:0]  best_id;
    } t_cell_ctl;

endpackage

>>> rtl/htw_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer wheel cell
// Holds one timer. During a scan it compares its own due offset with the
// best candidate handed in from its lower neighbor and passes the better one
// up the chain, so the chain end holds the earliest, lowest numbered timer.
// ----------------------------------------------------------------------------
module htw_cell
    import htw_pkg::*;
#(
    parameter int IdBits = 6,
    parameter int MyId   = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic              i_sel,
    input  logic              i_in_vld,
    input  logic [31:0]       i_in_off,
    input  logic [IdBits-1:0] i_in_id,
    output logic              o_out_vld,
    output logic [31:0]       o_out_off,
    output logic [IdBits-1:0] o_out_id,
    output logic              o_due
);

    logic        r_armed;
    logic [31:0] r_expiry;
    logic [31:0] w_off;
    logic        w_cand;
    logic        r_vld;
    logic [31:0] r_off;
    logic [IdBits-1:0] r_id;

    assign w_off  = r_expiry - i_ctl.cur_time;
    assign w_cand = r_armed && (w_off <= i_ctl.span);
    assign o_due  = w_cand;

    // Armed flag and expiry for this timer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_armed <= 1'b0;
        end else if (i_sel && i_ctl.add) begin
            r_armed <= 1'b1;
        end else if (i_sel && i_ctl.del) begin
            r_armed <= 1'b0;
        end else if (i_ctl.fire && w_cand && (IdBits'(MyId) == i_ctl.best_id)) begin
            r_armed <= 1'b0;
        end
        if (i_sel && i_ctl.add) begin
            r_expiry <= i_ctl.expiry;
        end
    end

    // Minimum stage: strict less-than keeps the lower number on a tie,
    // since the lower cells sit earlier in the chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.scan) begin
            if (w_cand && (!i_in_vld || w_off < i_in_off)) begin
                r_vld <= 1'b1;
            end else begin
                r_vld <= i_in_vld;
            end
        end
        if (w_cand && (!i_in_vld || w_off < i_in_off)) begin
            r_off <= w_off;
            r_id  <= IdBits'(MyId);
        end else begin
            r_off <= i_in_off;
            r_id  <= i_in_id;
        end
    end

    assign o_out_vld = r_vld;
    assign o_out_off = r_off;
    assign o_out_id  = r_id;

endmodule

>>> rtl/hierarchical_timer_wheel_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hierarchical timer wheel unit
// Sixty-four numbered timers with add, delete and advance commands.
// ----------------------------------------------------------------------------
// Add and delete update the addressed timer when accepted. An advance scans
// the chain of timer cells, the earliest candidate rippling one cell per
// cycle, and each scan that finds a timer is followed by the presentation of
// its expiry transaction, held until the receiver takes it, so an advance
// that fires n timers runs n scans, each followed by its expiry, and one
// that fires nothing runs a single scan.
// Firing order is expiry tick first, then ascending timer number.
// Writing start_time reloads the tick counter and disarms all timers.
// ----------------------------------------------------------------------------
module hierarchical_timer_wheel_unit
    import htw_pkg::*;
#(
    parameter int NUM_TIMERS       = 64,
    parameter int NEAR_WHEEL_BITS  = 8,
    parameter int OUTER_WHEEL_BITS = 6,
    parameter int MAX_DELAY        = 1073741823
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [5:0]  i_timer_id,
    input  logic [31:0] i_time_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_fired_timer,
    output logic [31:0] o_fired_time,
    output logic        o_last
);

    localparam int SpanBits = NEAR_WHEEL_BITS + 4 * OUTER_WHEEL_BITS;
    localparam longint CapL = (SpanBits < 32) ? ((64'sd1 <<< SpanBits) - 1) : 64'hFFFFFFFF;
    localparam longint LimL = (CapL < longint'(MAX_DELAY)) ? CapL : longint'(MAX_DELAY);
    localparam logic [31:0] Limit = LimL[31:0];
    localparam int CntBits = $clog2(NUM_TIMERS + 2);

    t_state      r_state, n_state;
    logic [31:0] r_cur, r_span, r_target;
    logic [CntBits-1:0] r_cnt;
    logic        r_ovld;
    logic [5:0]  r_oid;
    logic [31:0] r_otime;
    logic        r_olast;

    t_cell_ctl   w_ctl;
    logic        w_acc;
    logic [31:0] w_k;
    logic [NUM_TIMERS:0]      c_vld;
    logic [31:0]              c_off [NUM_TIMERS+1];
    logic [5:0]               c_id  [NUM_TIMERS+1];
    logic [NUM_TIMERS-1:0]    w_due;
    logic        w_done, w_more;

    assign w_acc = i_valid && o_ready;

    // Clamp of an add's delay.
    always_comb begin
        w_k = i_time_value - r_cur;
        if (w_k[31]) begin
            w_k = '0;
        end else if (w_k > Limit) begin
            w_k = Limit;
        end
    end

    // Scan ends when the candidate has left the last cell.
    assign w_done = (r_state == ST_SCAN) && (r_cnt == CntBits'(NUM_TIMERS));
    assign w_more = ($countones(w_due) > 1);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc && t_cmd'(i_cmd) == CMD_ADVANCE
                    && !(i_time_value - r_cur >= 32'h8000_0000)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_done) begin
                    n_state = c_vld[NUM_TIMERS] ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (!r_ovld || i_ready) begin
                    n_state = r_olast ? ST_IDLE : ST_SCAN;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the controller and the cell broadcast.
    always_comb begin
        o_ready        = (r_state == ST_IDLE) && !r_ovld;
        w_ctl.add      = w_acc && t_cmd'(i_cmd) == CMD_ADD;
        w_ctl.del      = w_acc && t_cmd'(i_cmd) == CMD_DELETE;
        w_ctl.scan     = (r_state == ST_SCAN);
        w_ctl.fire     = w_done && c_vld[NUM_TIMERS];
        w_ctl.clear    = i_cfg_we;
        w_ctl.expiry   = r_cur + w_k;
        w_ctl.cur_time = r_cur;
        w_ctl.span     = r_span;
        w_ctl.best_id  = c_id[NUM_TIMERS];
    end

    assign c_vld[0] = 1'b0;
    assign c_off[0] = '0;
    assign c_id[0]  = '0;

    // Chain of timer cells.
    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
        htw_cell #(.IdBits(6), .MyId(g)) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_sel    (i_timer_id == 6'(g)),
            .i_in_vld (c_vld[g]),
            .i_in_off (c_off[g]),
            .i_in_id  (c_id[g]),
            .o_out_vld(c_vld[g+1]),
            .o_out_off(c_off[g+1]),
            .o_out_id (c_id[g+1]),
            .o_due    (w_due[g])
        );
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cur   <= '0;
            r_cnt   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cur <= i_cfg_wdata;
            end else if (r_state == ST_IDLE && n_state == ST_SCAN) begin
                r_span   <= i_time_value - r_cur;
                r_target <= i_time_value;
            end else if (r_state != ST_IDLE && n_state == ST_IDLE) begin
                r_cur <= r_target + 32'd1;
            end
            if (r_state == ST_SCAN && !w_done) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
            // Output register: load the found timer, drop after handoff.
            if (w_ctl.fire) begin
                r_ovld  <= 1'b1;
                r_oid   <= c_id[NUM_TIMERS];
                r_otime <= r_cur + c_off[NUM_TIMERS];
                r_olast <= !w_more;
            end else if (r_ovld && i_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    assign o_valid       = r_ovld;
    assign o_fired_timer = r_oid;
    assign o_fired_time  = r_otime;
    assign o_last        = r_olast;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer wheel unit testbench
// Drives add, delete and advance commands with random idling and back
// pressure, predicts every expiry with a behavioral copy of the timer set,
// and checks each expiry transaction in order against that prediction.
// ----------------------------------------------------------------------------
module tb;
    import htw_pkg::*;

    localparam int NTIM      = 64;
    localparam int SPAN_BITS = 8 + 4 * 6;
    localparam int MAX_DLY   = 1073741823;
    localparam int TIMEOUT   = 4000000;
    localparam int STALL_CYC = 600;

    typedef struct {
        logic [5:0]  timer;
        logic [31:0] tick;
        logic        last;
    } t_expiry;

    // Scoreboard: holds the timer set and the queue of predicted expiries.
    class expiry_board;
        logic [31:0] now;
        logic [31:0] due[NTIM];
        bit          armed[NTIM];
        t_expiry     pending[$];
        int          errors;

        function void load(logic [31:0] t);
            now = t;
            foreach (armed[i]) begin
                armed[i] = 0;
                due[i]   = 0;
            end
        endfunction

        // Update the timer set for one accepted command transaction.
        function void note_command(t_cmd c, logic [5:0] id, logic [31:0] tv);
            logic [31:0] k, lim, span, off, best;
            int          pick, first;
            lim = (SPAN_BITS < 32 && ((64'd1 << SPAN_BITS) - 1) < MAX_DLY) ?
                  32'((64'd1 << SPAN_BITS) - 1) : 32'(MAX_DLY);
            case (c)
                CMD_ADD: begin
                    k = tv - now;
                    if (k[31]) k = 0;
                    else if (k > lim) k = lim;
                    due[id]   = now + k;
                    armed[id] = 1;
                end
                CMD_DELETE: armed[id] = 0;
                CMD_ADVANCE: begin
                    span = tv - now;
                    if (!span[31]) begin
                        first = pending.size();
                        // Pull the earliest remaining timer, lowest number on ties.
                        forever begin
                            pick = -1;
                            best = 0;
                            for (int i = 0; i < NTIM; i++) begin
                                off = due[i] - now;
                                if (armed[i] && off <= span && (pick < 0 || off < best)) begin
                                    pick = i;
                                    best = off;
                                end
                            end
                            if (pick < 0) break;
                            armed[pick] = 0;
                            pending.push_back('{6'(pick), now + best, 1'b0});
                        end
                        if (pending.size() > first)
                            pending[pending.size() - 1].last = 1;
                        now = tv + 1;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_expiry(logic [5:0] t, logic [31:0] tk, logic l);
            t_expiry e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected expiry exp none act timer=%0d time=%h last=%b",
                         $time, t, tk, l);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.timer !== t) begin
                $display("%0t: fired_timer exp %0d act %0d", $time, e.timer, t);
                errors++;
            end
            if (e.tick !== tk) begin
                $display("%0t: fired_time exp %h act %h", $time, e.tick, tk);
                errors++;
            end
            if (e.last !== l) begin
                $display("%0t: last exp %b act %b", $time, e.last, l);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [31:0] cfg_wdata = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [1:0]  cmd = CMD_NONE;
    logic [5:0]  timer_id = 0;
    logic [31:0] time_value = 0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [5:0]  fired_timer;
    logic [31:0] fired_time;
    logic        fired_last;

    expiry_board board;
    int          cycles = 0;
    bit          calm = 0;
    int          hold_off = 0;
    int          stall_req = 0;
    int          stall_ack = 0;

    hierarchical_timer_wheel_unit uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_cmd(cmd), .i_timer_id(timer_id), .i_time_value(time_value),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_fired_timer(fired_timer), .o_fired_time(fired_time), .o_last(fired_last)
    );

    always begin
        #4 clk = 1;
        #4 clk = 0;
    end

    // Cycle limit.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > TIMEOUT) begin
            $display("[hierarchical_timer_wheel_unit] ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, a long hold-off on request, checks on acceptance.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            board.check_expiry(fired_timer, fired_time, fired_last);
        if (stall_ack != stall_req) begin
            stall_ack <= stall_req;
            hold_off  <= STALL_CYC;
            out_ready <= 0;
        end else if (hold_off > 0) begin
            hold_off  <= hold_off - 1;
            out_ready <= 0;
        end else begin
            out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 6);
        end
    end

    // Send one command transaction, with an optional random idle gap first.
    task automatic send(t_cmd c, logic [5:0] id, logic [31:0] tv);
        while (!calm && $urandom_range(99) < 6) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid   <= 1;
        cmd        <= c;
        timer_id   <= id;
        time_value <= tv;
        do @(posedge clk); while (!in_ready);
        board.note_command(c, id, tv);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_start(logic [31:0] t);
        drain();
        cfg_we    <= 1;
        cfg_wdata <= t;
        @(posedge clk);
        cfg_we <= 0;
        board.load(t);
    endtask

    // Random command: mostly adds near the current time and short advances.
    task automatic random_item();
        int          r;
        logic [31:0] tv;
        r = $urandom_range(99);
        if (r < 50) begin
            case ($urandom_range(3))
                0: tv = $urandom;
                1: tv = board.now - $urandom_range(50);
                default: tv = board.now + $urandom_range(300);
            endcase
            send(CMD_ADD, 6'($urandom_range(63)), tv);
        end else if (r < 62) begin
            send(CMD_DELETE, 6'($urandom_range(63)), $urandom);
        end else if (r < 95) begin
            tv = ($urandom_range(19) == 0) ? $urandom : board.now + $urandom_range(400);
            send(CMD_ADVANCE, 6'($urandom), tv);
        end else begin
            send(CMD_NONE, 6'($urandom), $urandom);
        end
    endtask

    initial begin
        logic [31:0] base;
        board = new();
        board.load(0);
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, past and clamped expiries, re-arm, ignored commands.
        calm = 1;
        send(CMD_ADD, 6'd0, 32'd5);
        send(CMD_ADD, 6'd63, 32'd5);
        send(CMD_ADD, 6'd7, 32'hFFFF_FFFF);
        send(CMD_ADD, 6'd8, 32'h7FFF_FFFF);
        send(CMD_ADD, 6'd9, 32'd20);
        send(CMD_ADD, 6'd9, 32'd3);
        send(CMD_DELETE, 6'd9, 32'd0);
        send(CMD_DELETE, 6'd10, 32'hFFFF_FFFF);
        send(CMD_NONE, 6'd63, 32'hFFFF_FFFF);
        send(CMD_ADVANCE, 6'd0, 32'd10);
        send(CMD_ADVANCE, 6'd0, 32'd2);
        send(CMD_ADD, 6'd1, 32'd0);
        send(CMD_ADVANCE, 6'd63, 32'd11);
        send(CMD_ADVANCE, 6'd0, 32'h0000_0000 + 32'd11 + 32'(MAX_DLY));
        write_start(32'hFFFF_FFF0);
        send(CMD_ADD, 6'd2, 32'h0000_0004);
        send(CMD_ADD, 6'd3, 32'hFFFF_FFF8);
        send(CMD_ADD, 6'd4, 32'hFFFF_FFF8);
        send(CMD_ADVANCE, 6'd0, 32'h0000_0008);
        write_start(32'h8000_0000);
        send(CMD_ADD, 6'd5, 32'h7FFF_FFFF);
        send(CMD_ADVANCE, 6'd0, 32'h8000_0000);
        calm = 0;

        // Back pressure: fill many timers, stall the receiver, keep sending.
        drain();
        stall_req = stall_req + 1;
        base = board.now;
        for (int i = 0; i < 40; i++)
            send(CMD_ADD, 6'(i), base + $urandom_range(8));
        send(CMD_ADVANCE, 6'd0, base + 10);
        for (int i = 0; i < 6; i++)
            random_item();

        // Random phases with several start settings.
        for (int p = 0; p < 4; p++) begin
            if (p == 1) write_start(32'hFFFF_FFFF);
            if (p == 2) write_start($urandom);
            if (p == 3) calm = 1;
            for (int i = 0; i < 30; i++)
                random_item();
            calm = 0;
            drain();
        end

        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("[hierarchical_timer_wheel_unit] OK");
        else
            $display("[hierarchical_timer_wheel_unit] ERROR");
        $finish;
    end
endmodule
